[rtl/rpn_pkg.sv]
// shared types and constants for the rpn stack calculator
package rpn_pkg;

  // command codes
  typedef enum logic [3:0] {
    FN_PUSH     = 4'd0,
    FN_ADD      = 4'd1,
    FN_SUB      = 4'd2,
    FN_MUL      = 4'd3,
    FN_DIV      = 4'd4,
    FN_NEG      = 4'd5,
    FN_DUP      = 4'd6,
    FN_SWAP     = 4'd7,
    FN_PRINT    = 4'd8,
    FN_CLEAR    = 4'd9,
    FN_PRINTALL = 4'd10,
    FN_BAD      = 4'd11
  } func_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_FEW      = 3'd2,
    KIND_DIVZERO  = 3'd3,
    KIND_OVERFLOW = 3'd4,
    KIND_BAD      = 3'd5
  } kind_e;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] out_value;
    logic               last;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    func_e       op;
    logic [31:0] value;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DIV_FIN,
    ST_WRITE2,
    ST_PA_RD,
    ST_PA_OUT,
    ST_RSP
  } state_e;

  localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] QMIN = 32'h8000_0000;

  // saturate a wide signed value to q16.16
  function automatic logic [31:0] sat64(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = QMAX;
    else if (x < -64'sh0000_0000_8000_0000) r = QMIN;
    else r = x[31:0];
    return r;
  endfunction

endpackage

[rtl/rpn_stack_calculator_core.sv]
// Reverse-Polish calculator on a stack of signed Q16.16 values. A front end
// queues up to two requests; a back end sequencer executes one command at a
// time against a single port stack ram. Div uses a restoring divider that
// produces one quotient bit per cycle, and print-all emits one response per
// stack entry, top of stack first.
// Responses leave through one output register that holds while stalled; a
// new command waits while that register holds a stalled response.
module rpn_stack_calculator_core import rpn_pkg::*; #(
  parameter int StackDepth = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  rpn_front u_front (
    .clk_i, .rst_ni, .req_valid_i(in_valid_i), .req_stall_o(in_stall_o),
    .req_i(in_req_i), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  rpn_back #(.StackDepth(StackDepth)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .rsp_valid_o(out_valid_o), .rsp_stall_i(out_stall_i), .rsp_o(out_rsp_o)
  );

  // a pop only happens when the queue holds a request
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop of empty queue");

  // only value responses carry a nonzero value
  a_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.kind != KIND_VALUE |-> out_rsp_o.out_value == '0)
    else $error("error response with value");

  // error responses always close the command
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.kind != KIND_VALUE |-> out_rsp_o.last)
    else $error("error response without last");
endmodule

[rtl/rpn_ram.sv]
// generic single port ram with registered read
module rpn_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

[rtl/rpn_front.sv]
// front end: accepts requests, classifies them and queues them for the back end
module rpn_front import rpn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic cmd_valid_o,
  input  logic cmd_pop_i,
  output cmd_t cmd_o
);
  // two entry queue
  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cls;

  // map out-of-range codes onto the bad command
  always_comb begin
    cls.value = req_i.push_value;
    if (req_i.func > 4'd10) cls.op = FN_BAD;
    else cls.op = func_e'(req_i.func);
  end

  assign req_stall_o = (cnt_q == 2'd2);
  assign push        = req_valid_i && !req_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end
endmodule

[rtl/rpn_back.sv]
// back end: executes commands on the stack ram and produces responses
module rpn_back import rpn_pkg::*; #(
  parameter int StackDepth = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o
);
  localparam int AW = $clog2(StackDepth);
  localparam int CW = $clog2(StackDepth + 1);
  localparam logic [CW-1:0] FULL = CW'(StackDepth);

  state_e      st_q, st_d;
  cmd_t        cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [5:0]  it_q, it_d;
  logic [47:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [63:0] prod_q, prod_d;
  rsp_t        rsp_q, rsp_d;
  logic        rv_q, rv_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;

  rpn_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [31:0] mag_a, mag_b;
  logic        neg_r;
  logic [48:0] trial;
  logic signed [63:0] add_w;

  assign mag_a = a_q[31] ? (~a_q + 32'd1) : a_q;
  assign mag_b = b_q[31] ? (~b_q + 32'd1) : b_q;
  assign neg_r = a_q[31] ^ b_q[31];
  assign trial = {rem_q, quo_q[47]} - {17'd0, mag_a};

  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  function automatic rsp_t mk(input kind_e k, input logic [31:0] v, input logic l);
    rsp_t r;
    r.kind = k; r.out_value = v; r.last = l;
    return r;
  endfunction

  // signed result from magnitude with saturation
  function automatic logic [31:0] sgn_sat(input logic n, input logic [47:0] m);
    logic [31:0] r;
    if (n) r = (m > 48'h8000_0000) ? QMIN : (~m[31:0] + 32'd1);
    else   r = (m > 48'h7FFF_FFFF) ? QMAX : m[31:0];
    return r;
  endfunction

  // sequencer
  always_comb begin
    st_d = st_q; cmd_d = cmd_q; cnt_d = cnt_q; a_d = a_q; b_d = b_q;
    idx_d = idx_q; it_d = it_q; rem_d = rem_q; quo_d = quo_q; prod_d = prod_q;
    rsp_d = rsp_q; rv_d = rv_q;
    cmd_pop_o = 1'b0; we = 1'b0; addr = '0; wdata = '0;
    add_w = '0;
    if (rv_q && !rsp_stall_i) rv_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        // take a new command only once the output register is free
        if (cmd_valid_i && (!rv_q || !rsp_stall_i)) begin
          cmd_pop_o = 1'b1;
          cmd_d = cmd_i;
          addr = AW'(cnt_q - CW'(1));
          unique case (cmd_i.op)
            FN_PUSH: begin
              if (cnt_q == FULL) begin
                rsp_d = mk(KIND_OVERFLOW, '0, 1'b1); st_d = ST_RSP;
              end else begin
                we = 1'b1; addr = AW'(cnt_q); wdata = cmd_i.value;
                cnt_d = cnt_q + CW'(1);
              end
            end
            FN_CLEAR: cnt_d = '0;
            FN_BAD: begin
              rsp_d = mk(KIND_BAD, '0, 1'b1); st_d = ST_RSP;
            end
            FN_PRINTALL: begin
              if (cnt_q == '0) begin
                rsp_d = mk(KIND_EMPTY, '0, 1'b1); st_d = ST_RSP;
              end else begin
                idx_d = cnt_q; st_d = ST_PA_RD;
              end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_SWAP: begin
              if (cnt_q < CW'(2)) begin
                rsp_d = mk(KIND_FEW, '0, 1'b1); st_d = ST_RSP;
              end else st_d = ST_RD_A;
            end
            default: begin
              if (cnt_q == '0) begin
                rsp_d = mk(KIND_FEW, '0, 1'b1); st_d = ST_RSP;
              end else st_d = ST_RD_A;
            end
          endcase
        end
      end
      ST_RD_A: begin
        a_d = rdata;
        addr = AW'(cnt_q - CW'(2));
        unique case (cmd_q.op)
          FN_DUP: begin
            if (cnt_q == FULL) begin
              rsp_d = mk(KIND_OVERFLOW, '0, 1'b1); st_d = ST_RSP;
            end else begin
              we = 1'b1; addr = AW'(cnt_q); wdata = rdata;
              cnt_d = cnt_q + CW'(1); st_d = ST_IDLE;
            end
          end
          FN_NEG: begin
            we = 1'b1; addr = AW'(cnt_q - CW'(1));
            wdata = (rdata == QMIN) ? QMAX : (~rdata + 32'd1);
            st_d = ST_IDLE;
          end
          FN_PRINT: begin
            rsp_d = mk(KIND_VALUE, rdata, 1'b1); st_d = ST_RSP;
          end
          FN_DIV: begin
            if (rdata == '0) begin
              rsp_d = mk(KIND_DIVZERO, '0, 1'b1); st_d = ST_RSP;
            end else if (cnt_q < CW'(2)) begin
              rsp_d = mk(KIND_FEW, '0, 1'b1); st_d = ST_RSP;
            end else st_d = ST_RD_B;
          end
          default: st_d = ST_RD_B;
        endcase
      end
      ST_RD_B: begin
        b_d = rdata;
        st_d = ST_EXEC;
      end
      ST_EXEC: begin
        addr = AW'(cnt_q - CW'(2));
        unique case (cmd_q.op)
          FN_SWAP: begin
            we = 1'b1; wdata = a_q; st_d = ST_WRITE2;
          end
          FN_ADD: begin
            add_w = 64'(signed'(b_q)) + 64'(signed'(a_q));
            we = 1'b1; wdata = sat64(add_w);
            cnt_d = cnt_q - CW'(1); st_d = ST_IDLE;
          end
          FN_SUB: begin
            add_w = 64'(signed'(b_q)) - 64'(signed'(a_q));
            we = 1'b1; wdata = sat64(add_w);
            cnt_d = cnt_q - CW'(1); st_d = ST_IDLE;
          end
          FN_MUL: begin
            prod_d = 64'(mag_a) * 64'(mag_b); st_d = ST_MUL;
          end
          default: begin
            rem_d = '0; quo_d = {mag_b, 16'd0}; it_d = '0; st_d = ST_DIV;
          end
        endcase
      end
      ST_MUL: begin
        addr = AW'(cnt_q - CW'(2));
        we = 1'b1; wdata = sgn_sat(neg_r, prod_q[63:16]);
        cnt_d = cnt_q - CW'(1); st_d = ST_IDLE;
      end
      ST_DIV: begin
        // one quotient bit per cycle, restoring
        if (!trial[48]) rem_d = trial[47:0];
        else rem_d = {rem_q[46:0], quo_q[47]};
        quo_d = {quo_q[46:0], !trial[48]};
        it_d = it_q + 6'd1;
        if (it_q == 6'd47) st_d = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        addr = AW'(cnt_q - CW'(2));
        we = 1'b1; wdata = sgn_sat(neg_r, quo_q);
        cnt_d = cnt_q - CW'(1); st_d = ST_IDLE;
      end
      ST_WRITE2: begin
        addr = AW'(cnt_q - CW'(1));
        we = 1'b1; wdata = b_q; st_d = ST_IDLE;
      end
      ST_PA_RD: begin
        addr = AW'(idx_q - CW'(1));
        st_d = ST_PA_OUT;
      end
      ST_PA_OUT: begin
        addr = AW'(idx_q - CW'(1));
        if (!rv_q || !rsp_stall_i) begin
          rv_d = 1'b1;
          rsp_d = mk(KIND_VALUE, rdata, idx_q == CW'(1));
          idx_d = idx_q - CW'(1);
          st_d = (idx_q == CW'(1)) ? ST_IDLE : ST_PA_RD;
        end
      end
      ST_RSP: begin
        if (!rv_q || !rsp_stall_i) begin
          rv_d = 1'b1; st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      cnt_q <= '0;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      rv_q <= rv_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; a_q <= a_d; b_q <= b_d; idx_q <= idx_d; it_q <= it_d;
    rem_q <= rem_d; quo_q <= quo_d; prod_q <= prod_d; rsp_q <= rsp_d;
  end
endmodule
